FILE: hdl/sui_pkg.sv
// Shared types and constants for the set union / intersection block.
package sui_pkg;

    localparam int DATA_W = 32;
    localparam int USZ_W  = 6;
    localparam int ISZ_W  = 5;

    typedef enum logic [1:0] {
        KIND_UNION = 2'd0,
        KIND_INTER = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNION_A,
        S_LAUNCH,
        S_WAIT,
        S_EMIT,
        S_END
    } state_t;

    // Membership probe travelling down the cell chain.
    typedef struct packed {
        logic              vld;
        logic              against_b;
        logic [DATA_W-1:0] value;
        logic              hit;
    } probe_t;

    // Element write toward the cell row.
    typedef struct packed {
        logic              a_en;
        logic              b_en;
        logic [DATA_W-1:0] data;
    } wr_t;

endpackage

FILE: hdl/set_union_intersection.sv
// Top level: set union / intersection over a chain of comparison cells.
// Load: in_ready is high whenever no run is active.
// Run (on B's last item): one cycle per A element for the union head while the output is not
// stalled by out_ready, then every B element and every A element travels the cell chain as a
// probe, one at a time: the next probe is launched only after the last one has returned.
// Reset: both sets empty, overflow flags clear, next item of either set starts a new load.
module set_union_intersection
    import sui_pkg::*;
#(
    parameter int SET_CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     target_set,
    input  logic                     has_value,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic                     last_element,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               result_kind,
    output logic signed [DATA_W-1:0] result_value,
    output logic [USZ_W-1:0]         union_size,
    output logic [ISZ_W-1:0]         intersection_size,
    output logic                     overflow_seen,
    output logic                     final_result
);

    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int IDX_W = SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1;

    wr_t               wr;
    logic [IDX_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  a_cnt;
    logic [CNT_W-1:0]  b_cnt;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    probe_t            launch;
    probe_t            ret;

    // Chain links: link[i] feeds cell i, link[SET_CAPACITY] is the returning probe.
    probe_t            link [SET_CAPACITY+1];
    logic [DATA_W-1:0] a_vals [SET_CAPACITY];
    logic [DATA_W-1:0] b_vals [SET_CAPACITY];

    sui_ctrl #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .target_set        (target_set),
        .has_value         (has_value),
        .element_value     (element_value),
        .last_element      (last_element),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .result_value      (result_value),
        .union_size        (union_size),
        .intersection_size (intersection_size),
        .overflow_seen     (overflow_seen),
        .final_result      (final_result),
        .wr                (wr),
        .wr_idx            (wr_idx),
        .a_cnt             (a_cnt),
        .b_cnt             (b_cnt),
        .rd_idx            (rd_idx),
        .rd_a              (rd_a),
        .rd_b              (rd_b),
        .launch            (launch),
        .ret               (ret)
    );

    assign link[0] = launch;
    assign ret     = link[SET_CAPACITY];

    // Each cell owns entry i of both sets; it is live while i is below that set's count,
    // so stale entries from an earlier, longer load never match.
    for (genvar i = 0; i < SET_CAPACITY; i++)
    begin : g_cell
        sui_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_a      (wr.a_en && (wr_idx == IDX_W'(i))),
            .wr_b      (wr.b_en && (wr_idx == IDX_W'(i))),
            .wr_data   (wr.data),
            .live_a    (CNT_W'(i) < a_cnt),
            .live_b    (CNT_W'(i) < b_cnt),
            .probe_in  (link[i]),
            .probe_out (link[i+1]),
            .a_val     (a_vals[i]),
            .b_val     (b_vals[i])
        );
    end

    // Sequencer readout: the element at the run index, for the union head and probe launch.
    assign rd_a = a_vals[rd_idx];
    assign rd_b = b_vals[rd_idx];

endmodule

FILE: hdl/sui_cell.sv
// One chain cell: holds one A entry and one B entry, compares the passing probe.
module sui_cell
    import sui_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_a,
    input  logic              wr_b,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              live_a,
    input  logic              live_b,
    input  probe_t            probe_in,
    output probe_t            probe_out,
    output logic [DATA_W-1:0] a_val,
    output logic [DATA_W-1:0] b_val
);

    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    probe_t            probe_reg;
    probe_t            probe_next;
    logic              in_range;
    logic [DATA_W-1:0] stored;

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_reg <= wr_data;
        end
        if (wr_b)
        begin
            b_reg <= wr_data;
        end
    end

    // match only entries inside the current load of the searched set
    always_comb
    begin
        in_range       = probe_in.against_b ? live_b : live_a;
        stored         = probe_in.against_b ? b_reg : a_reg;
        probe_next     = probe_in;
        probe_next.hit = probe_in.hit | (in_range && (stored == probe_in.value));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;
    assign a_val     = a_reg;
    assign b_val     = b_reg;

endmodule

FILE: hdl/sui_ctrl.sv
// Load bookkeeping, run sequencer and output register.
module sui_ctrl
    import sui_pkg::*;
#(
    parameter int SET_CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      target_set,
    input  logic                      has_value,
    input  logic signed [DATA_W-1:0]  element_value,
    input  logic                      last_element,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                result_kind,
    output logic signed [DATA_W-1:0]  result_value,
    output logic [USZ_W-1:0]          union_size,
    output logic [ISZ_W-1:0]          intersection_size,
    output logic                      overflow_seen,
    output logic                      final_result,
    output wr_t                       wr,
    output logic [(SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1)-1:0] wr_idx,
    output logic [$clog2(SET_CAPACITY + 1)-1:0] a_cnt,
    output logic [$clog2(SET_CAPACITY + 1)-1:0] b_cnt,
    output logic [(SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1)-1:0] rd_idx,
    input  logic [DATA_W-1:0]         rd_a,
    input  logic [DATA_W-1:0]         rd_b,
    output probe_t                    launch,
    input  probe_t                    ret
);

    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int IDX_W = SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SET_CAPACITY);

    state_t             state_reg, state_next;
    logic [1:0]         fresh_reg, fresh_next;
    logic [CNT_W-1:0]   a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0]   b_cnt_reg, b_cnt_next;
    logic               a_ovf_reg, a_ovf_next;
    logic               b_ovf_reg, b_ovf_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               phase_reg, phase_next;
    logic [USZ_W-1:0]   usz_reg, usz_next;
    logic [ISZ_W-1:0]   isz_reg, isz_next;
    logic [DATA_W-1:0]  pend_val_reg, pend_val_next;
    logic               pend_hit_reg, pend_hit_next;
    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic [DATA_W-1:0]  out_val_reg, out_val_next;
    logic [USZ_W-1:0]   out_usz_reg, out_usz_next;
    logic [ISZ_W-1:0]   out_isz_reg, out_isz_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_fin_reg, out_fin_next;

    logic               in_fire;
    logic               slot_free;
    logic               cur_fresh;
    logic [CNT_W-1:0]   base_cnt;
    logic               base_ovf;
    logic               room;
    logic [CNT_W-1:0]   new_cnt;
    logic               new_ovf;
    logic [CNT_W-1:0]   limit;
    logic [DATA_W-1:0]  probe_val;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // load bookkeeping: a fresh set restarts from empty on its first item
    always_comb
    begin
        cur_fresh = fresh_reg[target_set];
        base_cnt  = cur_fresh ? '0 : (target_set ? b_cnt_reg : a_cnt_reg);
        base_ovf  = cur_fresh ? 1'b0 : (target_set ? b_ovf_reg : a_ovf_reg);
        room      = base_cnt < CAP;
        new_cnt   = base_cnt + CNT_W'(has_value && room);
        new_ovf   = base_ovf | (has_value && !room);
        wr.a_en   = in_fire && has_value && room && !target_set;
        wr.b_en   = in_fire && has_value && room && target_set;
        wr.data   = element_value;
        wr_idx    = base_cnt[IDX_W-1:0];
    end

    always_comb
    begin
        fresh_next     = fresh_reg;
        a_cnt_next     = a_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        a_ovf_next     = a_ovf_reg;
        b_ovf_next     = b_ovf_reg;
        state_next     = state_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        usz_next       = usz_reg;
        isz_next       = isz_reg;
        pend_val_next  = pend_val_reg;
        pend_hit_next  = pend_hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_val_next   = out_val_reg;
        out_usz_next   = out_usz_reg;
        out_isz_next   = out_isz_reg;
        out_ovf_next   = out_ovf_reg;
        out_fin_next   = out_fin_reg;
        launch         = '0;
        limit          = phase_reg ? a_cnt_reg : b_cnt_reg;
        probe_val      = phase_reg ? rd_a : rd_b;

        if (in_fire)
        begin
            fresh_next[target_set] = last_element;
            if (target_set)
            begin
                b_cnt_next = new_cnt;
                b_ovf_next = new_ovf;
            end
            else
            begin
                a_cnt_next = new_cnt;
                a_ovf_next = new_ovf;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && target_set && last_element)
                begin
                    state_next = S_UNION_A;
                    idx_next   = '0;
                    usz_next   = '0;
                    isz_next   = '0;
                end
            end
            S_UNION_A:
            begin
                if (idx_reg < a_cnt_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_UNION;
                        out_val_next   = rd_a;
                        out_usz_next   = '0;
                        out_isz_next   = '0;
                        out_ovf_next   = 1'b0;
                        out_fin_next   = 1'b0;
                        idx_next       = idx_reg + CNT_W'(1);
                        usz_next       = usz_reg + USZ_W'(1);
                    end
                end
                else
                begin
                    idx_next   = '0;
                    phase_next = 1'b0;
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                if (idx_reg < limit)
                begin
                    launch.vld       = 1'b1;
                    launch.against_b = phase_reg;
                    launch.value     = probe_val;
                    pend_val_next    = probe_val;
                    state_next       = S_WAIT;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = S_END;
                end
            end
            S_WAIT:
            begin
                if (ret.vld)
                begin
                    pend_hit_next = ret.hit;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (phase_reg ? pend_hit_reg : !pend_hit_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = phase_reg ? KIND_INTER : KIND_UNION;
                        out_val_next   = pend_val_reg;
                        out_usz_next   = '0;
                        out_isz_next   = '0;
                        out_ovf_next   = 1'b0;
                        out_fin_next   = 1'b0;
                        if (phase_reg)
                        begin
                            isz_next = isz_reg + ISZ_W'(1);
                        end
                        else
                        begin
                            usz_next = usz_reg + USZ_W'(1);
                        end
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_LAUNCH;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_LAUNCH;
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_END;
                    out_val_next   = '0;
                    out_usz_next   = usz_reg;
                    out_isz_next   = isz_reg;
                    out_ovf_next   = a_ovf_reg | b_ovf_reg;
                    out_fin_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fresh_reg     <= 2'b11;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            a_ovf_reg     <= 1'b0;
            b_ovf_reg     <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            usz_reg       <= '0;
            isz_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            a_cnt_reg     <= a_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            a_ovf_reg     <= a_ovf_next;
            b_ovf_reg     <= b_ovf_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            usz_reg       <= usz_next;
            isz_reg       <= isz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg <= pend_val_next;
        pend_hit_reg <= pend_hit_next;
        out_kind_reg <= out_kind_next;
        out_val_reg  <= out_val_next;
        out_usz_reg  <= out_usz_next;
        out_isz_reg  <= out_isz_next;
        out_ovf_reg  <= out_ovf_next;
        out_fin_reg  <= out_fin_next;
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = out_kind_reg;
    assign result_value      = out_val_reg;
    assign union_size        = out_usz_reg;
    assign intersection_size = out_isz_reg;
    assign overflow_seen     = out_ovf_reg;
    assign final_result      = out_fin_reg;
    assign a_cnt             = a_cnt_reg;
    assign b_cnt             = b_cnt_reg;
    assign rd_idx            = idx_reg[IDX_W-1:0];

    a_probe_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ret.vld |-> state_reg == S_WAIT)
        else $error("probe returned outside the wait state");

    a_launch_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        launch.vld |=> state_reg == S_WAIT)
        else $error("probe launch not followed by wait");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_cnt_reg <= CAP && b_cnt_reg <= CAP)
        else $error("set count beyond capacity");

    a_inter_within_union: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fin_reg |-> USZ_W'(out_isz_reg) <= out_usz_reg)
        else $error("intersection larger than union on end marker");

endmodule
